/* sv/mtcm_pkg.sv */
// ----------------------------------------------------------------------------
// mtcm_pkg
// Shared widths, register indexes, reset values and the controller/datapath
// command and status types of the motor tach and current monitor.
// ----------------------------------------------------------------------------
package mtcm_pkg;

   // default length of the current averaging ring
   localparam int CURRENT_WINDOW_DEF = 8;

   // field widths
   localparam int TIME_W      = 32;
   localparam int SAMPLE_W    = 10;
   localparam int DRIVE_W     = 8;
   localparam int FACTOR_W    = 16;
   localparam int TIMEOUT_W   = 24;
   localparam int THRESH_W    = 10;
   localparam int LIMIT_W     = 16;
   localparam int SPEED_W     = 24;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam logic [CSR_INDEX_W-1:0] CSR_HIGH_FACTOR   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_FACTOR    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_STALL_TIMEOUT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DRIVE_THRESH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURRENT_THRESH = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_STALL_LIMIT   = 3'd5;

   // register reset values
   localparam logic [FACTOR_W-1:0]  HIGH_FACTOR_RST    = 16'd4096;
   localparam logic [FACTOR_W-1:0]  LOW_FACTOR_RST     = 16'd4096;
   localparam logic [TIMEOUT_W-1:0] STALL_TIMEOUT_RST  = 24'd330000;
   localparam logic [DRIVE_W-1:0]   DRIVE_THRESH_RST   = 8'd30;
   localparam logic [THRESH_W-1:0]  CURRENT_THRESH_RST = 10'd20;
   localparam logic [LIMIT_W-1:0]   STALL_LIMIT_RST    = 16'd500;

   // 1e6 / 256 = 15625 / 4: numerator is (factor * 15625) >> 2
   localparam int                      SPEED_SCALE_W = 14;
   localparam logic [SPEED_SCALE_W-1:0] SPEED_SCALE  = 14'd15625;
   localparam int                      NUMER_W       = FACTOR_W + SPEED_SCALE_W - 2;
   localparam logic [SPEED_W-1:0]      SPEED_MAX     = 24'hFFFFFF;

   // controller to datapath commands
   typedef struct packed {
      logic capture;      // latch the request, read the ring slot
      logic ring_update;  // write the ring, update sum, elapsed time, numerator
      logic avg_mult;     // multiply sum by the window reciprocal
      logic div_start;    // launch the period division
      logic finish;       // commit state and load the response register
   } mtcm_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic edge_found;
      logic div_busy;
   } mtcm_status_type;

endpackage

/* sv/mtcm_ram.sv */
// ----------------------------------------------------------------------------
// mtcm_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module mtcm_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 8
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/mtcm_div.sv */
// ----------------------------------------------------------------------------
// mtcm_div
// Radix-2 restoring divider: speed numerator by the 32-bit period, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module mtcm_div
   import mtcm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [NUMER_W-1:0] dividend,
   input  logic [TIME_W-1:0]  divisor,
   output logic               busy,
   output logic [NUMER_W-1:0] quotient
);

   localparam int CNT_W = $clog2(NUMER_W + 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [TIME_W-1:0] rem_ff, rem_in;
   logic [TIME_W-1:0] divisor_ff, divisor_in;
   logic [NUMER_W-1:0] quo_ff, quo_in;
   logic [TIME_W:0]   trial;
   logic [TIME_W:0]   diff;
   logic              fits;

   // one shift-and-subtract step
   always_comb begin
      trial      = {rem_ff, quo_ff[NUMER_W-1]};
      diff       = trial - {1'b0, divisor_ff};
      fits       = (trial >= {1'b0, divisor_ff});
      busy_in    = busy_ff;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = CNT_W'(NUMER_W);
         rem_in     = '0;
         quo_in     = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
         quo_in   = {quo_ff[NUMER_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   // partial remainder and quotient
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

/* sv/mtcm_datapath.sv */
// ----------------------------------------------------------------------------
// mtcm_datapath
// Configuration registers, current averaging ring, period measurement,
// stall integral and the response register of the monitor.
// ----------------------------------------------------------------------------
module mtcm_datapath
   import mtcm_pkg::*;
#(
   parameter int CURRENT_WINDOW = CURRENT_WINDOW_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  mtcm_cmd_type           cmd,
   output mtcm_status_type        status,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic [TIME_W-1:0]      req_time_us,
   input  logic                   req_tach_level,
   input  logic [SAMPLE_W-1:0]    req_current_sample,
   input  logic [DRIVE_W-1:0]     req_drive_level,
   input  logic                   req_motor_enabled,
   output logic [SPEED_W-1:0]     rsp_speed,
   output logic [SAMPLE_W-1:0]    rsp_avg_current,
   output logic                   rsp_edge_seen,
   output logic                   rsp_stall_timeout_hit,
   output logic                   rsp_fault_trip
);

   localparam int POS_W     = (CURRENT_WINDOW > 1) ? $clog2(CURRENT_WINDOW) : 1;
   localparam int SUM_W     = SAMPLE_W + $clog2(CURRENT_WINDOW);
   // sum / window = (sum * AVG_MULT) >> AVG_SHIFT, exact for every sum
   localparam int AVG_SHIFT = SUM_W + $clog2(CURRENT_WINDOW);
   localparam int PROD_W    = SUM_W + AVG_SHIFT + 1;
   localparam logic [AVG_SHIFT:0] AVG_MULT =
      (AVG_SHIFT + 1)'(((64'd1 << AVG_SHIFT) + 64'(CURRENT_WINDOW) - 64'd1) /
                       64'(CURRENT_WINDOW));

   // configuration
   logic [FACTOR_W-1:0]  high_factor_ff, high_factor_in;
   logic [FACTOR_W-1:0]  low_factor_ff, low_factor_in;
   logic [TIMEOUT_W-1:0] timeout_ff, timeout_in;
   logic [DRIVE_W-1:0]   drive_thresh_ff, drive_thresh_in;
   logic [THRESH_W-1:0]  current_thresh_ff, current_thresh_in;
   logic [LIMIT_W-1:0]   stall_limit_ff, stall_limit_in;

   // monitor state
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               wrapped_ff, wrapped_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               last_tach_ff, last_tach_in;
   logic [TIME_W-1:0]  last_edge_ff, last_edge_in;
   logic [SPEED_W-1:0] speed_hold_ff, speed_hold_in;
   logic [LIMIT_W-1:0] accum_ff, accum_in;

   // captured request and intermediate values
   logic [TIME_W-1:0]   time_ff;
   logic                tach_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [DRIVE_W-1:0]  drive_ff;
   logic                enabled_ff;
   logic [TIME_W-1:0]   elapsed_ff;
   logic                edge_ff;
   logic [NUMER_W-1:0]  numer_ff, numer_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;

   // response register
   logic [SPEED_W-1:0]  rsp_speed_ff;
   logic [SAMPLE_W-1:0] rsp_avg_ff;
   logic                rsp_edge_ff;
   logic                rsp_timeout_ff;
   logic                rsp_fault_ff;

   logic [SAMPLE_W-1:0] ram_rdata;
   logic [SAMPLE_W-1:0] old_sample;
   logic [SUM_W:0]      sum_wide;
   logic [FACTOR_W-1:0] factor_sel;
   logic [FACTOR_W+SPEED_SCALE_W-1:0] numer_prod;
   logic [NUMER_W-1:0]  quotient;
   logic                div_busy;
   logic [SPEED_W-1:0]  speed_edge;
   logic [SAMPLE_W-1:0] avg;
   logic                timeout;
   logic                drive_hot;
   logic [LIMIT_W:0]    accum_sum;
   logic [LIMIT_W-1:0]  accum_sat;
   logic                fault;

   // current ring storage
   mtcm_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (CURRENT_WINDOW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (cmd.ring_update),
      .wr_addr (pos_ff),
      .wr_data (sample_ff),
      .rd_en   (cmd.capture),
      .rd_addr (pos_ff),
      .rd_data (ram_rdata)
   );

   // period divider
   mtcm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (numer_ff),
      .divisor  (elapsed_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // configuration writes
   always_comb begin
      high_factor_in    = high_factor_ff;
      low_factor_in     = low_factor_ff;
      timeout_in        = timeout_ff;
      drive_thresh_in   = drive_thresh_ff;
      current_thresh_in = current_thresh_ff;
      stall_limit_in    = stall_limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_HIGH_FACTOR:    high_factor_in    = csr_wdata[FACTOR_W-1:0];
            CSR_LOW_FACTOR:     low_factor_in     = csr_wdata[FACTOR_W-1:0];
            CSR_STALL_TIMEOUT:  timeout_in        = csr_wdata[TIMEOUT_W-1:0];
            CSR_DRIVE_THRESH:   drive_thresh_in   = csr_wdata[DRIVE_W-1:0];
            CSR_CURRENT_THRESH: current_thresh_in = csr_wdata[THRESH_W-1:0];
            CSR_STALL_LIMIT:    stall_limit_in    = csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // ring update, running sum and speed numerator
   always_comb begin
      old_sample = wrapped_ff ? ram_rdata : '0;
      sum_wide   = {1'b0, sum_ff} - (SUM_W + 1)'(old_sample) + (SUM_W + 1)'(sample_ff);
      factor_sel = tach_ff ? high_factor_ff : low_factor_ff;
      numer_prod = (FACTOR_W + SPEED_SCALE_W)'(factor_sel) *
                   (FACTOR_W + SPEED_SCALE_W)'(SPEED_SCALE);
      numer_in   = numer_prod[NUMER_W+1:2];
      prod_in    = PROD_W'(sum_ff) * PROD_W'(AVG_MULT);
      pos_in     = pos_ff;
      wrapped_in = wrapped_ff;
      sum_in     = sum_ff;
      if (cmd.ring_update) begin
         sum_in = sum_wide[SUM_W-1:0];
         if (pos_ff == POS_W'(CURRENT_WINDOW - 1)) begin
            pos_in     = '0;
            wrapped_in = 1'b1;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // edge speed, timeout and stall checks
   always_comb begin
      avg        = prod_ff[AVG_SHIFT +: SAMPLE_W];
      if (numer_ff == '0) begin
         speed_edge = '0;
      end else if (quotient > NUMER_W'(SPEED_MAX)) begin
         speed_edge = SPEED_MAX;
      end else begin
         speed_edge = quotient[SPEED_W-1:0];
      end
      timeout    = !edge_ff && (elapsed_ff > TIME_W'(timeout_ff));
      drive_hot  = (drive_ff > drive_thresh_ff);
      accum_sum  = {1'b0, accum_ff} + (LIMIT_W + 1)'(drive_ff);
      accum_sat  = accum_sum[LIMIT_W] ? {LIMIT_W{1'b1}} : accum_sum[LIMIT_W-1:0];

      last_tach_in  = last_tach_ff;
      last_edge_in  = last_edge_ff;
      speed_hold_in = speed_hold_ff;
      accum_in      = accum_ff;
      fault         = 1'b0;
      if (cmd.finish) begin
         if (edge_ff) begin
            last_tach_in  = tach_ff;
            last_edge_in  = time_ff;
            speed_hold_in = speed_edge;
            accum_in      = '0;
         end else if (timeout) begin
            last_edge_in  = time_ff;
            speed_hold_in = '0;
            if (enabled_ff) begin
               if (drive_hot && (avg > current_thresh_ff)) begin
                  accum_in = accum_sat;
                  fault    = (accum_sat > stall_limit_ff);
               end else if (drive_hot && (avg < current_thresh_ff)) begin
                  fault = 1'b1;
               end
            end else begin
               accum_in = '0;
            end
         end
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         high_factor_ff    <= HIGH_FACTOR_RST;
         low_factor_ff     <= LOW_FACTOR_RST;
         timeout_ff        <= STALL_TIMEOUT_RST;
         drive_thresh_ff   <= DRIVE_THRESH_RST;
         current_thresh_ff <= CURRENT_THRESH_RST;
         stall_limit_ff    <= STALL_LIMIT_RST;
         pos_ff            <= '0;
         wrapped_ff        <= 1'b0;
         sum_ff            <= '0;
         last_tach_ff      <= 1'b0;
         last_edge_ff      <= '0;
         speed_hold_ff     <= '0;
         accum_ff          <= '0;
      end else begin
         high_factor_ff    <= high_factor_in;
         low_factor_ff     <= low_factor_in;
         timeout_ff        <= timeout_in;
         drive_thresh_ff   <= drive_thresh_in;
         current_thresh_ff <= current_thresh_in;
         stall_limit_ff    <= stall_limit_in;
         pos_ff            <= pos_in;
         wrapped_ff        <= wrapped_in;
         sum_ff            <= sum_in;
         last_tach_ff      <= last_tach_in;
         last_edge_ff      <= last_edge_in;
         speed_hold_ff     <= speed_hold_in;
         accum_ff          <= accum_in;
      end
   end

   // request capture and intermediate results
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         time_ff    <= req_time_us;
         tach_ff    <= req_tach_level;
         sample_ff  <= req_current_sample;
         drive_ff   <= req_drive_level;
         enabled_ff <= req_motor_enabled;
      end
      if (cmd.ring_update) begin
         elapsed_ff <= time_ff - last_edge_ff;
         edge_ff    <= (tach_ff != last_tach_ff);
         numer_ff   <= numer_in;
      end
      if (cmd.avg_mult) begin
         prod_ff <= prod_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_speed_ff   <= speed_hold_in;
         rsp_avg_ff     <= avg;
         rsp_edge_ff    <= edge_ff;
         rsp_timeout_ff <= timeout;
         rsp_fault_ff   <= fault;
      end
   end

   assign status.edge_found    = edge_ff;
   assign status.div_busy      = div_busy;
   assign rsp_speed            = rsp_speed_ff;
   assign rsp_avg_current      = rsp_avg_ff;
   assign rsp_edge_seen        = rsp_edge_ff;
   assign rsp_stall_timeout_hit = rsp_timeout_ff;
   assign rsp_fault_trip       = rsp_fault_ff;

endmodule

/* sv/mtcm_ctrl.sv */
// ----------------------------------------------------------------------------
// mtcm_ctrl
// Sequencer of the monitor: walks one request through ring update, average,
// optional period division and commit, and owns the response valid flag.
// ----------------------------------------------------------------------------
module mtcm_ctrl
   import mtcm_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output mtcm_cmd_type    cmd,
   input  mtcm_status_type status
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_AVG  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.ring_update = 1'b1;
            state_in        = ST_AVG;
         end
         ST_AVG: begin
            cmd.avg_mult = 1'b1;
            if (status.edge_found) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_FIN;
            end
         end
         ST_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.finish   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/motor_tach_current_monitor.sv */
// ----------------------------------------------------------------------------
// motor_tach_current_monitor
// Tachometer period speed measurement with current averaging and stall
// detection.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one sample tick (timestamp, tach level, current sample,
//   drive level, enable). A request is taken when req_valid is high and
//   req_stall is low. rsp_* returns exactly one response per request, taken
//   when rsp_valid is high and rsp_stall is low.
//   csr_* writes configuration registers by index (0..5, higher ignored);
//   csr_ready is always high. Write only while no request is in flight.
// Sequencing:
//   a tick is worked through ring update, average and commit; a tick
//   with an edge adds the radix-2 period division, one quotient bit per
//   cycle over 28 bits, before the commit. Only one request is in flight:
//   req_stall stays high until its response is loaded, and the next
//   request can be taken the cycle after.
// Reset (synchronous): clears the ring fill state, sums, edge time, speed,
//   stall integral and response valid; registers go to their defaults.
// Stall: a held response keeps its payload; a new request may be taken and
//   worked on, and its result waits until the response register frees up.
// ----------------------------------------------------------------------------
module motor_tach_current_monitor
   import mtcm_pkg::*;
#(
   parameter int CURRENT_WINDOW = CURRENT_WINDOW_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [TIME_W-1:0]      req_time_us,
   input  logic                   req_tach_level,
   input  logic [SAMPLE_W-1:0]    req_current_sample,
   input  logic [DRIVE_W-1:0]     req_drive_level,
   input  logic                   req_motor_enabled,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [SPEED_W-1:0]     rsp_speed,
   output logic [SAMPLE_W-1:0]    rsp_avg_current,
   output logic                   rsp_edge_seen,
   output logic                   rsp_stall_timeout_hit,
   output logic                   rsp_fault_trip,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   mtcm_cmd_type    cmd;
   mtcm_status_type status;

   // configuration is always accepted
   assign csr_ready = 1'b1;

   mtcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   mtcm_datapath #(
      .CURRENT_WINDOW (CURRENT_WINDOW)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .csr_we                (csr_valid & csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .req_time_us           (req_time_us),
      .req_tach_level        (req_tach_level),
      .req_current_sample    (req_current_sample),
      .req_drive_level       (req_drive_level),
      .req_motor_enabled     (req_motor_enabled),
      .rsp_speed             (rsp_speed),
      .rsp_avg_current       (rsp_avg_current),
      .rsp_edge_seen         (rsp_edge_seen),
      .rsp_stall_timeout_hit (rsp_stall_timeout_hit),
      .rsp_fault_trip        (rsp_fault_trip)
   );

endmodule

/* sv/mtcm_checker.sv */
// ----------------------------------------------------------------------------
// mtcm_checker
// Port-level checks of the monitor's response channel, bound to the top.
// ----------------------------------------------------------------------------
module mtcm_checker
   import mtcm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [SPEED_W-1:0] rsp_speed,
   input logic               rsp_edge_seen,
   input logic               rsp_stall_timeout_hit,
   input logic               rsp_fault_trip
);

   // no response survives reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_speed) && $stable(rsp_fault_trip))
      else $error("stalled response changed");

   // a tick is never both an edge and a timeout
   a_edge_timeout_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_edge_seen && rsp_stall_timeout_hit))
      else $error("edge and timeout in one response");

   // timeout forces zero speed
   a_timeout_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall_timeout_hit |-> rsp_speed == '0)
      else $error("timeout with nonzero speed");

   // faults are only raised on a timeout tick
   a_fault_on_timeout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault_trip |-> rsp_stall_timeout_hit)
      else $error("fault without timeout");

endmodule

bind motor_tach_current_monitor mtcm_checker u_checker (.*);
